@@ sv/oahm_pkg.sv @@
// ----------------------------------------------------------------------------
// oahm_pkg
// shared types, codes and the probe hash for the open address hash map unit
// ----------------------------------------------------------------------------
package oahm_pkg;

    // field widths fixed by the interface
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int TOMB_W   = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LOAD_LIMIT  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_PROBE_LIMIT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOMB_MARKER  = 1'b1;

    // reset values of the marker registers
    localparam logic [KEY_W-1:0] EMPTY_MARKER_RST = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0] TOMB_MARKER_RST  = 32'hFFFF_FFFE;

    // control states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_CLEAR,
        S_RESP
    } state_t;

    // xorshift step between probes (left 13, right 17, left 5)
    function automatic logic [KEY_W-1:0] next_hash(input logic [KEY_W-1:0] h);
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        a = h ^ (h << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

@@ sv/open_address_hash_map_unit.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_map_unit
// key/value table with open addressing, xorshift probing and tombstones
// ----------------------------------------------------------------------------
// accept issues the first read; S_PROBE examines P slots, P being the slots probed
//   (1 to MAX_PROBES); S_RESP loads the result; marker keys and refused inserts
//   skip S_PROBE, a clear sweeps all TABLE_DEPTH slots; one transaction at
//   a time, one key memory read per probe, and S_RESP waits for a free output register
// reset: after reset a pass writes the empty marker into all TABLE_DEPTH slots,
//   one per cycle, and no transaction is accepted until it ends
module open_address_hash_map_unit
    import oahm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_PROBES  = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_wdata,
    // command channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [KEY_W-1:0]     key,
    input  logic [DATA_W-1:0]    data_in,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [DATA_W-1:0]    data_out,
    output logic [STATUS_W-1:0]  status,
    output logic [LIVE_W-1:0]    live_entries
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH / 2 + 1);
    localparam int PCNT_W = $clog2(MAX_PROBES + 1);
    localparam int LOAD_W = FILL_W + 2;

    // state registers
    state_t               state_reg, state_next;
    logic [KEY_W-1:0]     empty_marker_reg, empty_marker_next;
    logic [KEY_W-1:0]     tomb_marker_reg, tomb_marker_next;
    logic [KEY_W-1:0]     wipe_val_reg, wipe_val_next;
    logic [IDX_W-1:0]     sweep_cnt_reg, sweep_cnt_next;
    logic [PCNT_W-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [TOMB_W-1:0]    tomb_reg, tomb_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [DATA_W-1:0]    din_reg, din_next;
    logic [KEY_W-1:0]     hash_reg, hash_next;
    logic                 res_found_reg, res_found_next;
    logic [DATA_W-1:0]    res_data_reg, res_data_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 found_reg, found_next;
    logic [DATA_W-1:0]    data_out_reg, data_out_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [LIVE_W-1:0]    live_reg, live_next;

    // memory ports
    logic [KEY_W-1:0]     key_mem [TABLE_DEPTH];
    logic [DATA_W-1:0]    val_mem [TABLE_DEPTH];
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic [KEY_W-1:0]     rd_key;
    logic [DATA_W-1:0]    rd_val;
    logic                 key_we;
    logic                 val_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_W-1:0]     key_wdata;

    // decode helpers
    logic                 accept;
    logic                 in_is_marker;
    logic                 load_full;
    logic [LOAD_W-1:0]    load_sum;
    logic [KEY_W-1:0]     start_hash;
    logic [KEY_W-1:0]     step_hash;
    logic                 rd_hit;
    logic                 rd_empty;
    logic                 rd_tomb;
    logic                 last_probe;
    logic                 sweep_last;
    logic                 out_free;
    logic [TOMB_W-1:0]    fill_ext;
    logic [TOMB_W-1:0]    live_full;

    assign accept       = in_valid && in_ready;
    assign in_is_marker = (key == empty_marker_reg) || (key == tomb_marker_reg);
    assign load_sum     = {1'b0, fill_reg, 1'b1};
    assign load_full    = load_sum >= LOAD_W'(TABLE_DEPTH);
    assign start_hash   = key + KEY_W'(1);
    assign step_hash    = next_hash(hash_reg);
    assign rd_hit       = rd_key == key_reg;
    assign rd_empty     = rd_key == empty_marker_reg;
    assign rd_tomb      = rd_key == tomb_marker_reg;
    assign last_probe   = probe_cnt_reg == PCNT_W'(MAX_PROBES - 1);
    assign sweep_last   = sweep_cnt_reg == IDX_W'(TABLE_DEPTH - 1);
    assign out_free     = !out_valid_reg || out_ready;
    assign fill_ext     = TOMB_W'(fill_reg);
    assign live_full    = (fill_ext > tomb_reg) ? fill_ext - tomb_reg : '0;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign data_out     = data_out_reg;
    assign status       = status_reg;
    assign live_entries = live_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == CMD_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (in_is_marker || (cmd == CMD_INSERT && load_full))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                priority if (cmd_reg == CMD_INSERT)
                begin
                    if (rd_empty || rd_tomb || last_probe)
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    if (rd_hit || rd_empty || last_probe)
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory control and counters
    always_comb
    begin
        empty_marker_next = empty_marker_reg;
        tomb_marker_next  = tomb_marker_reg;
        wipe_val_next     = wipe_val_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        probe_cnt_next    = probe_cnt_reg;
        fill_next         = fill_reg;
        tomb_next         = tomb_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        din_next          = din_reg;
        hash_next         = hash_reg;
        res_found_next    = res_found_reg;
        res_data_next     = res_data_reg;
        res_status_next   = res_status_reg;
        found_next        = found_reg;
        data_out_next     = data_out_reg;
        status_next       = status_reg;
        live_next         = live_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mem_re            = 1'b0;
        mem_raddr         = start_hash[IDX_W-1:0];
        key_we            = 1'b0;
        val_we            = 1'b0;
        mem_waddr         = hash_reg[IDX_W-1:0];
        key_wdata         = key_reg;

        // marker registers: the user must write them only while idle; the block does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EMPTY_MARKER: empty_marker_next = cfg_wdata;
                CFG_TOMB_MARKER:  tomb_marker_next  = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                // sweep one slot per cycle
                key_we         = 1'b1;
                mem_waddr      = sweep_cnt_reg;
                key_wdata      = wipe_val_reg;
                sweep_cnt_next = sweep_cnt_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd;
                    key_next        = key;
                    din_next        = data_in;
                    hash_next       = start_hash;
                    probe_cnt_next  = '0;
                    res_found_next  = 1'b0;
                    res_data_next   = '0;
                    res_status_next = STAT_OK;
                    // first probe read issued with the accept
                    mem_re          = 1'b1;
                    mem_raddr       = start_hash[IDX_W-1:0];
                    priority if (cmd == CMD_CLEAR)
                    begin
                        fill_next      = '0;
                        tomb_next      = '0;
                        wipe_val_next  = empty_marker_reg;
                        sweep_cnt_next = '0;
                    end
                    else if (in_is_marker)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                    else if (cmd == CMD_INSERT && load_full)
                    begin
                        res_status_next = STAT_LOAD_LIMIT;
                    end
                    else
                    begin
                        res_status_next = STAT_OK;
                    end
                end
            end
            S_PROBE:
            begin
                priority if (cmd_reg == CMD_INSERT && (rd_empty || rd_tomb))
                begin
                    // claim the first free slot of the chain
                    key_we          = 1'b1;
                    val_we          = 1'b1;
                    key_wdata       = key_reg;
                    res_status_next = STAT_OK;
                    if (rd_empty)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else if (tomb_reg != '0)
                    begin
                        tomb_next = tomb_reg - TOMB_W'(1);
                    end
                end
                else if (cmd_reg != CMD_INSERT && rd_hit)
                begin
                    res_found_next  = 1'b1;
                    res_status_next = STAT_OK;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_data_next = rd_val;
                    end
                    else
                    begin
                        // remove leaves a tombstone
                        key_we    = 1'b1;
                        key_wdata = tomb_marker_reg;
                        if (tomb_reg != '1)
                        begin
                            tomb_next = tomb_reg + TOMB_W'(1);
                        end
                    end
                end
                else if (cmd_reg != CMD_INSERT && rd_empty)
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
                else if (last_probe)
                begin
                    res_status_next = STAT_PROBE_LIMIT;
                end
                else
                begin
                    // walk on to the next slot of the chain
                    hash_next      = step_hash;
                    probe_cnt_next = probe_cnt_reg + PCNT_W'(1);
                    mem_re         = 1'b1;
                    mem_raddr      = step_hash[IDX_W-1:0];
                end
            end
            S_RESP:
            begin
                // load the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    data_out_next  = res_data_reg;
                    status_next    = res_status_reg;
                    live_next      = live_full[LIVE_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            empty_marker_reg <= EMPTY_MARKER_RST;
            tomb_marker_reg  <= TOMB_MARKER_RST;
            wipe_val_reg     <= EMPTY_MARKER_RST;
            sweep_cnt_reg    <= '0;
            probe_cnt_reg    <= '0;
            fill_reg         <= '0;
            tomb_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            empty_marker_reg <= empty_marker_next;
            tomb_marker_reg  <= tomb_marker_next;
            wipe_val_reg     <= wipe_val_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            probe_cnt_reg    <= probe_cnt_next;
            fill_reg         <= fill_next;
            tomb_reg         <= tomb_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        din_reg        <= din_next;
        hash_reg       <= hash_next;
        res_found_reg  <= res_found_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        found_reg      <= found_next;
        data_out_reg   <= data_out_next;
        status_reg     <= status_next;
        live_reg       <= live_next;
    end

    // key store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[mem_waddr] <= key_wdata;
        end
        if (mem_re)
        begin
            rd_key <= key_mem[mem_raddr];
        end
    end

    // value store, same addressing as the key store
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[mem_waddr] <= din_reg;
        end
        if (mem_re)
        begin
            rd_val <= val_mem[mem_raddr];
        end
    end

`ifndef ASSERT_OFF
    // a slot is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && (key_we || val_we)))
        else $error("key store read and written in one cycle");

    // a probe read is always pending when a chain slot is examined
    a_probe_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> $past(mem_re))
        else $error("probe without a prior read");

    // the probe counter stays below the limit
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (probe_cnt_reg < PCNT_W'(MAX_PROBES)))
        else $error("probe counter past limit");

    // filled count never passes half the table
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_DEPTH / 2))
        else $error("filled count beyond load limit");

    // a clear reports an empty table
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && cmd_reg == CMD_CLEAR && out_free)
        |=> (out_valid_reg && live_reg == '0))
        else $error("clear result with live entries");
`endif

endmodule

@@ tb/hash_map_result_checker.sv @@
// ----------------------------------------------------------------------------
// hash_map_result_checker
// watches the command, result and register ports of the hash map unit, keeps
// a shadow copy of the slot table, and compares every result, field by field,
// with the answer that the shadow table gives for the matching command
// ----------------------------------------------------------------------------
module hash_map_result_checker
    import oahm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_PROBES  = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [KEY_W-1:0]     key,
    input  logic [DATA_W-1:0]    data_in,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 found,
    input  logic [DATA_W-1:0]    data_out,
    input  logic [STATUS_W-1:0]  status,
    input  logic [LIVE_W-1:0]    live_entries,
    output int                   failures
);

    typedef struct packed {
        logic                hit;
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] code;
        logic [LIVE_W-1:0]   live;
    } answer_t;

    // shadow table and markers
    logic [KEY_W-1:0]  slot_key   [TABLE_DEPTH];
    logic [DATA_W-1:0] slot_value [TABLE_DEPTH];
    logic [31:0]       taken_slots;
    logic [31:0]       tombstones;
    logic [KEY_W-1:0]  empty_key;
    logic [KEY_W-1:0]  tomb_key;

    answer_t pending_answers [$];
    answer_t next_answer;
    int      mismatches      = 0;
    int      outstanding     = 0;
    int      results_checked = 0;

    assign failures = mismatches + outstanding;

    // one xorshift step of the probe sequence
    function automatic logic [KEY_W-1:0] probe_step(input logic [KEY_W-1:0] h);
        logic [KEY_W-1:0] x;
        x = h;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    task automatic wipe_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_key[i] = empty_key;
        end
        taken_slots = '0;
        tombstones  = '0;
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
        begin
            $display("[%0t] hash map mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // run one command against the shadow table and work out its answer
    task automatic apply_command(
        input  logic [CMD_W-1:0]  c,
        input  logic [KEY_W-1:0]  k,
        input  logic [DATA_W-1:0] d,
        output answer_t           ans
    );
        logic [KEY_W-1:0] h;
        logic [KEY_W-1:0] held;
        logic [31:0]      live_full;
        int               idx;
        bit               done;

        ans      = '0;
        ans.code = STAT_OK;
        if (c == CMD_CLEAR)
        begin
            wipe_table();
        end
        else if (k == empty_key || k == tomb_key)
        begin
            ans.code = STAT_NOT_FOUND;
        end
        else if (c == CMD_INSERT)
        begin
            if (taken_slots * 2 + 1 >= TABLE_DEPTH)
            begin
                ans.code = STAT_LOAD_LIMIT;
            end
            else
            begin
                ans.code = STAT_PROBE_LIMIT;
                h        = k + 1;
                done     = 1'b0;
                for (int n = 0; n < MAX_PROBES && !done; n++)
                begin
                    idx  = int'(h & (TABLE_DEPTH - 1));
                    held = slot_key[idx];
                    if (held == empty_key || held == tomb_key)
                    begin
                        // first free slot: fresh slots grow the count, reused ones drop a tombstone
                        if (held == empty_key)
                            taken_slots++;
                        else if (tombstones > 0)
                            tombstones--;
                        slot_key[idx]   = k;
                        slot_value[idx] = d;
                        ans.code        = STAT_OK;
                        done            = 1'b1;
                    end
                    else
                    begin
                        h = probe_step(h);
                    end
                end
            end
        end
        else
        begin
            // lookup and remove walk the chain until the key or an empty slot
            ans.code = STAT_PROBE_LIMIT;
            h        = k + 1;
            done     = 1'b0;
            for (int n = 0; n < MAX_PROBES && !done; n++)
            begin
                idx  = int'(h & (TABLE_DEPTH - 1));
                held = slot_key[idx];
                if (held == k)
                begin
                    done     = 1'b1;
                    ans.hit  = 1'b1;
                    ans.code = STAT_OK;
                    if (c == CMD_LOOKUP)
                    begin
                        ans.value = slot_value[idx];
                    end
                    else
                    begin
                        slot_key[idx] = tomb_key;
                        if (tombstones != 32'hFFFF_FFFF)
                            tombstones++;
                    end
                end
                else if (held == empty_key)
                begin
                    done     = 1'b1;
                    ans.code = STAT_NOT_FOUND;
                end
                else
                begin
                    h = probe_step(h);
                end
            end
        end
        live_full = (taken_slots > tombstones) ? taken_slots - tombstones : 32'd0;
        ans.live  = live_full[LIVE_W-1:0];
    endtask

    // compare one result transaction with the oldest pending answer
    task automatic check_result();
        answer_t want;

        if (pending_answers.size() == 0)
        begin
            report_mismatch("result transaction with no command pending");
        end
        else
        begin
            want = pending_answers.pop_front();
            outstanding--;
            results_checked++;
            if (found !== want.hit)
                report_mismatch($sformatf("result %0d found: got %b, expected %b",
                    results_checked, found, want.hit));
            if (data_out !== want.value)
                report_mismatch($sformatf("result %0d data_out: got 0x%h, expected 0x%h",
                    results_checked, data_out, want.value));
            if (status !== want.code)
                report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                    results_checked, status, want.code));
            if (live_entries !== want.live)
                report_mismatch($sformatf("result %0d live_entries: got %0d, expected %0d",
                    results_checked, live_entries, want.live));
        end
    endtask

    // follow register writes, results and commands
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_key = EMPTY_MARKER_RST;
            tomb_key  = TOMB_MARKER_RST;
            wipe_table();
            pending_answers.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_EMPTY_MARKER)
                    empty_key = cfg_wdata;
                else if (cfg_index == CFG_TOMB_MARKER)
                    tomb_key = cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (in_valid && in_ready)
            begin
                apply_command(cmd, key, data_in, next_answer);
                pending_answers.push_back(next_answer);
                outstanding++;
            end
        end
    end

endmodule

@@ tb/open_address_hash_map_unit_test.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_map_unit_test
// drives commands and marker settings into the hash map unit with random
// gaps and back-pressure; a side checker predicts and compares each result
// ----------------------------------------------------------------------------
module open_address_hash_map_unit_test;
    import oahm_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_PROBES  = 64;
    localparam int CYCLE_LIMIT = 1000000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic [CMD_W-1:0]     cmd       = CMD_INSERT;
    logic [KEY_W-1:0]     key       = '0;
    logic [DATA_W-1:0]    data_in   = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 found;
    logic [DATA_W-1:0]    data_out;
    logic [STATUS_W-1:0]  status;
    logic [LIVE_W-1:0]    live_entries;

    int failures;
    int commands_sent = 0;
    int results_seen  = 0;
    int cycles        = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    bit steady      = 1'b0;
    bit shield_zero = 1'b0;

    logic [KEY_W-1:0] cur_empty = EMPTY_MARKER_RST;
    logic [KEY_W-1:0] cur_tomb  = TOMB_MARKER_RST;
    logic [KEY_W-1:0] key_pool [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    open_address_hash_map_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PROBES  (MAX_PROBES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .data_out     (data_out),
        .status       (status),
        .live_entries (live_entries)
    );

    hash_map_result_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PROBES  (MAX_PROBES)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .data_out     (data_out),
        .status       (status),
        .live_entries (live_entries),
        .failures     (failures)
    );

    // result side back-pressure
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 28);
    end

    // result tally and watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (out_valid && out_ready)
        begin
            results_seen++;
            status_seen[status]++;
        end
        if (cycles == CYCLE_LIMIT)
        begin
            $display("open_address_hash_map_unit_test failed");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] corner_key(input int n);
        case (n)
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'hFFFF_FFFD;
            5:       return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // one command transaction, with a random gap in front
    task automatic send_item(
        input logic [CMD_W-1:0]  c,
        input logic [KEY_W-1:0]  k,
        input logic [DATA_W-1:0] d
    );
        while (!steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        data_in  <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        commands_sent++;
        @(negedge clk);
    endtask

    // hold off until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_seen != commands_sent)
            @(negedge clk);
    endtask

    task automatic set_markers(input logic [KEY_W-1:0] e, input logic [KEY_W-1:0] t);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EMPTY_MARKER;
        cfg_wdata <= e;
        @(negedge clk);
        cfg_index <= CFG_TOMB_MARKER;
        cfg_wdata <= t;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_empty = e;
        cur_tomb  = t;
    endtask

    // random command: keys lean on earlier inserts and on colliding chains
    task automatic random_item(input int w_ins, input int w_look, input int w_rem,
                               input int w_clr);
        logic [CMD_W-1:0]  c;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] d;
        int                pick;
        int                bias;

        pick = $urandom_range(w_ins + w_look + w_rem + w_clr - 1);
        if (pick < w_ins)
            c = CMD_INSERT;
        else if (pick < w_ins + w_look)
            c = CMD_LOOKUP;
        else if (pick < w_ins + w_look + w_rem)
            c = CMD_REMOVE;
        else
            c = CMD_CLEAR;

        bias = $urandom_range(99);
        if (bias < 4)
            k = ($urandom_range(1) == 1) ? cur_empty : cur_tomb;
        else if (bias < 10)
            k = corner_key($urandom_range(6));
        else if (key_pool.size() > 0 && bias < ((c == CMD_INSERT) ? 25 : 75))
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (bias < 90)
            k = ($urandom() << 10) | ($urandom_range(7) * 97);
        else
            k = $urandom();

        // slots left over from an old clear hold key zero with no value behind it
        if (shield_zero && c == CMD_REMOVE && $urandom_range(1) == 1)
            k = '0;
        if (shield_zero && c == CMD_LOOKUP && k == '0)
            k = 32'd1;

        if ($urandom_range(9) == 0)
            d = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
            d = $urandom();

        if (c == CMD_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > 256)
                key_pool.delete(0);
        end
        if (c == CMD_CLEAR)
            key_pool.delete();

        if ($urandom_range(99) == 0)
            drain();
        send_item(c, k, d);
    endtask

    task automatic run_phase(input int n_items, input int w_ins, input int w_look,
                             input int w_rem, input int w_clr);
        for (int i = 0; i < n_items; i++)
        begin
            random_item(w_ins, w_look, w_rem, w_clr);
        end
        drain();
    endtask

    // stimulus
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme keys, marker keys, duplicates, collisions, tombstone reuse
        send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_INSERT, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFD, 32'h0000_0000);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_INSERT, 32'h0000_0400, 32'hA5A5_A5A5);
        send_item(CMD_LOOKUP, 32'h0000_0800, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'h0000_0400, 32'h0000_0000);
        send_item(CMD_CLEAR,  32'hDEAD_0001, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'h0000_0400, 32'h0000_0000);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_CLEAR,  $urandom(), $urandom());
        drain();

        // insert-heavy fill up to the load limit, with a stretch of no idling
        run_phase(200, 90, 7, 3, 0);
        steady = 1'b1;
        run_phase(200, 90, 7, 3, 0);
        steady = 1'b0;
        run_phase(300, 90, 7, 3, 0);

        // low markers, then a tombstone change that keeps the table
        set_markers(32'h0000_0000, 32'h0000_0001);
        send_item(CMD_CLEAR, $urandom(), $urandom());
        run_phase(180, 40, 35, 22, 3);
        set_markers(32'h0000_0000, 32'hFFFF_FFFF);
        run_phase(130, 40, 35, 22, 3);

        // old empty slots turn into tombstones: chains run to the probe limit
        set_markers(32'h5A5A_5A5A, 32'h0000_0000);
        run_phase(80, 30, 40, 30, 0);

        // old empty slots turn into live keys: inserts hit the probe limit too
        shield_zero = 1'b1;
        set_markers(32'h3C3C_3C3C, 32'hA5A5_A5A5);
        run_phase(80, 45, 35, 20, 0);
        shield_zero = 1'b0;

        // both markers equal, then high empty with a zero tombstone
        set_markers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_CLEAR, $urandom(), $urandom());
        run_phase(130, 40, 35, 22, 3);
        set_markers(32'h8000_0000, 32'h0000_0000);
        send_item(CMD_CLEAR, $urandom(), $urandom());
        run_phase(130, 40, 35, 22, 3);

        // let any stray result show up
        repeat (MAX_PROBES + 8) @(negedge clk);

        $display("%0d commands over 7 marker settings, %0d results compared",
            commands_sent, results_seen);
        $display("result status mix: ok %0d, not found %0d, load limit %0d, probe limit %0d",
            status_seen[STAT_OK], status_seen[STAT_NOT_FOUND],
            status_seen[STAT_LOAD_LIMIT], status_seen[STAT_PROBE_LIMIT]);
        if (failures == 0)
        begin
            $display("open_address_hash_map_unit_test passed");
        end
        else
        begin
            $display("open_address_hash_map_unit_test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/oahm_pkg.sv
sv/open_address_hash_map_unit.sv
tb/hash_map_result_checker.sv
tb/open_address_hash_map_unit_test.sv
